### hdl/tksd_pkg.sv
// Shared types and constants for the terminal key sequence decoder.
// Used by tksd_chunk, tksd_decode and terminal_key_sequence_decoder_top.
// No dependencies.
package tksd_pkg;

  localparam int unsigned HeadBytes = 4;
  localparam int unsigned LenW      = 3;  // decode length 1..5

  // Key codes carried on the key_code output field.
  localparam logic [4:0] KC_INCOMPLETE = 5'd0;
  localparam logic [4:0] KC_CHAR       = 5'd1;
  localparam logic [4:0] KC_ESC        = 5'd2;
  localparam logic [4:0] KC_ENTER      = 5'd3;
  localparam logic [4:0] KC_TAB        = 5'd4;
  localparam logic [4:0] KC_BACKSPACE  = 5'd5;
  localparam logic [4:0] KC_UP         = 5'd6;
  localparam logic [4:0] KC_DOWN       = 5'd7;
  localparam logic [4:0] KC_RIGHT      = 5'd8;
  localparam logic [4:0] KC_LEFT       = 5'd9;
  localparam logic [4:0] KC_HOME       = 5'd10;
  localparam logic [4:0] KC_END        = 5'd11;
  localparam logic [4:0] KC_INSERT     = 5'd12;
  localparam logic [4:0] KC_DELETE     = 5'd13;
  localparam logic [4:0] KC_PGUP       = 5'd14;
  localparam logic [4:0] KC_PGDN       = 5'd15;
  localparam logic [4:0] KC_F1         = 5'd16;
  localparam logic [4:0] KC_F2         = 5'd17;
  localparam logic [4:0] KC_F3         = 5'd18;
  localparam logic [4:0] KC_F4         = 5'd19;
  localparam logic [4:0] KC_F5         = 5'd20;
  localparam logic [4:0] KC_F6         = 5'd21;
  localparam logic [4:0] KC_F7         = 5'd22;
  localparam logic [4:0] KC_F8         = 5'd23;
  localparam logic [4:0] KC_F9         = 5'd24;
  localparam logic [4:0] KC_F10        = 5'd25;
  localparam logic [4:0] KC_F11        = 5'd26;
  localparam logic [4:0] KC_F12        = 5'd27;
  localparam logic [4:0] KC_LAST       = KC_F12;

  // Special byte values.
  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] CR_BYTE    = 8'h0d;
  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] BS_BYTE    = 8'h08;
  localparam logic [7:0] DEL_BYTE   = 8'h7f;
  localparam logic [7:0] TILDE_BYTE = 8'h7e;
  localparam logic [7:0] CTRL_BIAS  = 8'h60;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // Chunk view handed from the chunk tracker to the decoder.
  typedef struct packed {
    logic [HeadBytes-1:0][7:0] head;   // first four bytes, zero past the end
    logic                      tilde4; // fifth byte was '~'
    logic [LenW-1:0]           len;    // effective length, capped at five
    logic                      last;   // this byte closes the chunk
  } chunk_t;

  // One decoded key event.
  typedef struct packed {
    logic       alt;
    logic       ctrl;
    logic [7:0] ch;
    logic [4:0] code;
  } key_evt_t;

endpackage

### hdl/terminal_key_sequence_decoder_top.sv
// Top level of the terminal key sequence decoder.
// Depends on tksd_pkg, tksd_chunk and tksd_decode.
//
// Usage:
//   Raw terminal bytes enter on the slave stream, one byte per transaction,
//   with tlast marking the end of a read burst. Bytes are grouped into chunks;
//   a chunk closes on a byte with tlast set or on its CHUNK_BYTES-th byte.
//   Exactly one key event leaves on the master stream for each chunk, decoded
//   from at most the first five bytes; later bytes only count toward length.
//   Bytes that do not close a chunk produce no output transaction.
//
//   The event for a chunk's closing byte is valid on the master side in the
//   cycle after that byte is accepted. Throughput is one byte per cycle,
//   set by the single output register: a new byte is taken whenever the
//   output register is empty or is being drained in the same cycle. When
//   the receiver stalls, the pending event holds and the slave side
//   deasserts tready until it is taken.
//
//   Reset (rst_ni low, asynchronous) empties the output register and starts
//   a fresh chunk. The head byte store needs no clearing.
module terminal_key_sequence_decoder_top #(
  parameter int unsigned CHUNK_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream: tdata[7:0] in_byte; tlast is burst_end.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  // Master stream: tdata[4:0] key_code, [12:5] char_value, [13] ctrl_mod,
  // [14] alt_mod, [15] zero.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o
);
  import tksd_pkg::*;

  logic     s_accept;
  chunk_t   chunk;
  key_evt_t evt;
  logic     out_valid_q, out_valid_d;
  key_evt_t out_evt_q;

  // The output register can take a new event when it is empty or draining.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  tksd_chunk #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_chunk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (s_accept),
    .byte_i     (s_axis_tdata_i),
    .burst_end_i(s_axis_tlast_i),
    .chunk_o    (chunk)
  );

  tksd_decode u_decode (
    .chunk_i(chunk),
    .evt_o  (evt)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (s_accept && chunk.last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Event payload loads only when a chunk closes.
  always_ff @(posedge clk_i) begin
    if (s_accept && chunk.last) begin
      out_evt_q <= evt;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_evt_q.alt, out_evt_q.ctrl, out_evt_q.ch,
                            out_evt_q.code};

  // A new event appears only after a chunk-closing byte was accepted.
  a_evt_from_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s_accept && chunk.last))
    else $error("output event without a closing byte");

  // A stalled event blocks input so it is never overwritten.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted over a stalled event");

  // Delivered key codes stay inside the defined set.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_evt_q.code <= KC_LAST))
    else $error("key code out of range");

  // Modifiers only accompany character events and never both at once.
  a_mod_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_evt_q.ctrl || out_evt_q.alt)) |->
      (out_evt_q.code == KC_CHAR && !(out_evt_q.ctrl && out_evt_q.alt)))
    else $error("modifier on a non-character event");

endmodule

### hdl/tksd_chunk.sv
// Chunk tracker: byte counter, head byte store and fifth-byte tilde flag.
// Depends on tksd_pkg.
module tksd_chunk #(
  parameter int unsigned CHUNK_BYTES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      byte_i,
  input  logic            burst_end_i,
  output tksd_pkg::chunk_t chunk_o
);
  import tksd_pkg::*;

  localparam int unsigned CntW = $clog2(CHUNK_BYTES);

  logic [CntW-1:0]           count_q, count_d;
  logic                      tilde_q, tilde_d;
  logic [HeadBytes-1:0][7:0] head_q;
  logic                      at_fifth;
  logic                      in_head;

  assign at_fifth = (count_q == CntW'(4));
  assign in_head  = (count_q < CntW'(4));

  always_comb begin
    chunk_o.last = burst_end_i || (count_q == CntW'(CHUNK_BYTES - 1));
    for (int i = 0; i < HeadBytes; i++) begin
      if (CntW'(i) < count_q) begin
        chunk_o.head[i] = head_q[i];
      end else if (CntW'(i) == count_q) begin
        chunk_o.head[i] = byte_i;
      end else begin
        chunk_o.head[i] = 8'h00;
      end
    end
    chunk_o.tilde4 = at_fifth ? (byte_i == TILDE_BYTE) : tilde_q;
    chunk_o.len    = in_head ? (LenW'(count_q[1:0]) + LenW'(1)) : LenW'(5);
  end

  always_comb begin
    count_d = count_q;
    tilde_d = tilde_q;
    if (accept_i) begin
      if (chunk_o.last) begin
        count_d = '0;
        tilde_d = 1'b0;
      end else begin
        count_d = count_q + CntW'(1);
        if (at_fifth) begin
          tilde_d = (byte_i == TILDE_BYTE);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tilde_q <= 1'b0;
    end else begin
      count_q <= count_d;
      tilde_q <= tilde_d;
    end
  end

  // Head bytes hold payload only; entries are read only once written.
  always_ff @(posedge clk_i) begin
    if (accept_i && !chunk_o.last && in_head) begin
      head_q[count_q[1:0]] <= byte_i;
    end
  end

endmodule

### hdl/tksd_decode.sv
// Key decoder: turns the head of a chunk into one key event.
// Purely combinational. Depends on tksd_pkg.
module tksd_decode (
  input  tksd_pkg::chunk_t   chunk_i,
  output tksd_pkg::key_evt_t evt_o
);
  import tksd_pkg::*;

  logic [7:0]      b0, b1, b2, b3;
  logic [LenW-1:0] len;
  logic            full5;
  logic            matched;
  logic            incomplete;
  logic [4:0]      seq_code;

  assign b0    = chunk_i.head[0];
  assign b1    = chunk_i.head[1];
  assign b2    = chunk_i.head[2];
  assign b3    = chunk_i.head[3];
  assign len   = chunk_i.len;
  assign full5 = (len == LenW'(5)) && chunk_i.tilde4;

  // Escape sequence matcher. Incomplete means the sequence needs more bytes.
  always_comb begin
    matched    = 1'b0;
    incomplete = 1'b0;
    seq_code   = KC_INCOMPLETE;
    if (b1 == "[") begin
      if (len < LenW'(3)) begin
        incomplete = 1'b1;
      end else begin
        matched = 1'b1;
        case (b2)
          "A":     seq_code = KC_UP;
          "B":     seq_code = KC_DOWN;
          "C":     seq_code = KC_RIGHT;
          "D":     seq_code = KC_LEFT;
          "H":     seq_code = KC_HOME;
          "F":     seq_code = KC_END;
          default: matched  = 1'b0;
        endcase
        if (!matched && b2 >= "0" && b2 <= "9") begin
          if (len < LenW'(4)) begin
            incomplete = 1'b1;
          end else begin
            if (b3 == TILDE_BYTE) begin
              matched = 1'b1;
              case (b2)
                "1", "7": seq_code = KC_HOME;
                "4", "8": seq_code = KC_END;
                "2":      seq_code = KC_INSERT;
                "3":      seq_code = KC_DELETE;
                "5":      seq_code = KC_PGUP;
                "6":      seq_code = KC_PGDN;
                default:  matched  = 1'b0;
              endcase
            end
            if (!matched && full5 && b2 == "1") begin
              matched = 1'b1;
              case (b3)
                "5":     seq_code = KC_F5;
                "7":     seq_code = KC_F6;
                "8":     seq_code = KC_F7;
                "9":     seq_code = KC_F8;
                default: matched  = 1'b0;
              endcase
            end
            if (!matched && full5 && b2 == "2") begin
              matched = 1'b1;
              case (b3)
                "0":     seq_code = KC_F9;
                "1":     seq_code = KC_F10;
                "3":     seq_code = KC_F11;
                "4":     seq_code = KC_F12;
                default: matched  = 1'b0;
              endcase
            end
          end
        end
      end
    end else if (b1 == "O") begin
      if (len < LenW'(3)) begin
        incomplete = 1'b1;
      end else begin
        matched = 1'b1;
        case (b2)
          "P":     seq_code = KC_F1;
          "Q":     seq_code = KC_F2;
          "R":     seq_code = KC_F3;
          "S":     seq_code = KC_F4;
          default: matched  = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    evt_o = '0;
    if (b0 == ESC_BYTE) begin
      if (len == LenW'(1)) begin
        evt_o.code = KC_ESC;
      end else if (incomplete) begin
        evt_o.code = KC_INCOMPLETE;
      end else if (matched) begin
        evt_o.code = seq_code;
      end else begin
        // Unrecognized escape: treat it as Alt plus the second byte.
        evt_o.code = KC_CHAR;
        evt_o.ch   = b1;
        evt_o.alt  = 1'b1;
      end
    end else if (b0 == CR_BYTE) begin
      evt_o.code = KC_ENTER;
    end else if (b0 == TAB_BYTE) begin
      evt_o.code = KC_TAB;
    end else if (b0 == BS_BYTE || b0 == DEL_BYTE) begin
      evt_o.code = KC_BACKSPACE;
    end else if (b0 < CTRL_LIMIT) begin
      evt_o.code = KC_CHAR;
      evt_o.ch   = b0 + CTRL_BIAS;
      evt_o.ctrl = 1'b1;
    end else begin
      evt_o.code = KC_CHAR;
      evt_o.ch   = b0;
    end
  end

endmodule

### tb/terminal_key_sequence_decoder_top_test.sv
// Self-checking testbench for terminal_key_sequence_decoder_top: drives raw terminal bytes
// on the slave stream, predicts one key event per chunk and checks the master stream.
// Depends on tksd_pkg and the decoder RTL only.
module terminal_key_sequence_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tksd_pkg::*;

  localparam int unsigned ChunkBytes  = 16;
  localparam int unsigned RandItems   = 1725;
  localparam int unsigned CalmItems   = 150;   // tail of the run with no idling
  localparam int unsigned LongHold    = 400;   // receiver hold-off, in cycles
  localparam int unsigned HoldAfter   = 300;   // bytes taken before the hold-off
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 200000;

  localparam logic [7:0] CSI_INTRO = 8'h5b;  // '[' after ESC
  localparam logic [7:0] SS3_INTRO = 8'h4f;  // 'O' after ESC

  localparam logic [7:0] CSI_FINALS [6] = '{"A", "B", "C", "D", "H", "F"};
  localparam logic [7:0] SS3_FINALS [4] = '{"P", "Q", "R", "S"};

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } term_byte_t;

  // One row of the directed table. Where typed is set, want is the event that the
  // row's closing byte must produce; otherwise the predictor supplies it.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    key_evt_t   want;
  } dir_row_t;

  localparam key_evt_t NO_EVT = '0;

  localparam dir_row_t DIR_TAB [25] = '{
    // Bare escape.
    '{ESC_BYTE,   1'b1, 1'b1, '{1'b0, 1'b0, 8'h00, KC_ESC}},
    // Incomplete CSI: ESC [ and nothing more.
    '{ESC_BYTE,   1'b0, 1'b0, NO_EVT},
    '{CSI_INTRO,  1'b1, 1'b1, '{1'b0, 1'b0, 8'h00, KC_INCOMPLETE}},
    // Cursor up.
    '{ESC_BYTE,   1'b0, 1'b0, NO_EVT},
    '{CSI_INTRO,  1'b0, 1'b0, NO_EVT},
    '{"A",        1'b1, 1'b0, NO_EVT},
    // F1 through SS3.
    '{ESC_BYTE,   1'b0, 1'b0, NO_EVT},
    '{SS3_INTRO,  1'b0, 1'b0, NO_EVT},
    '{"P",        1'b1, 1'b0, NO_EVT},
    // F12 as ESC [ 2 4 ~, the tilde in the fifth byte.
    '{ESC_BYTE,   1'b0, 1'b0, NO_EVT},
    '{CSI_INTRO,  1'b0, 1'b0, NO_EVT},
    '{"2",        1'b0, 1'b0, NO_EVT},
    '{"4",        1'b0, 1'b0, NO_EVT},
    '{TILDE_BYTE, 1'b1, 1'b0, NO_EVT},
    // Unknown escape falls back to Alt plus the second byte.
    '{ESC_BYTE,   1'b0, 1'b0, NO_EVT},
    '{"x",        1'b1, 1'b1, '{1'b1, 1'b0, "x", KC_CHAR}},
    // Lowest byte is Ctrl plus a backtick, highest byte is a plain character.
    '{8'h00,      1'b1, 1'b1, '{1'b0, 1'b1, 8'h60, KC_CHAR}},
    '{8'hff,      1'b1, 1'b1, '{1'b0, 1'b0, 8'hff, KC_CHAR}},
    '{CR_BYTE,    1'b1, 1'b1, '{1'b0, 1'b0, 8'h00, KC_ENTER}},
    '{TAB_BYTE,   1'b1, 1'b1, '{1'b0, 1'b0, 8'h00, KC_TAB}},
    '{DEL_BYTE,   1'b1, 1'b1, '{1'b0, 1'b0, 8'h00, KC_BACKSPACE}},
    // Delete as ESC [ 3 ~.
    '{ESC_BYTE,   1'b0, 1'b0, NO_EVT},
    '{CSI_INTRO,  1'b0, 1'b0, NO_EVT},
    '{"3",        1'b0, 1'b0, NO_EVT},
    '{TILDE_BYTE, 1'b1, 1'b0, NO_EVT}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] in_byte
  logic        s_axis_tlast_i;   // burst_end
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // [4:0] key_code, [12:5] char_value, [13] ctrl_mod,
                                 // [14] alt_mod, [15] zero

  terminal_key_sequence_decoder_top #(
    .CHUNK_BYTES(ChunkBytes)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Predictor state: position in the current chunk, its first four bytes and
  // whether the fifth byte was a tilde.
  int unsigned     chunk_pos;
  logic [3:0][7:0] chunk_head;
  logic            fifth_tilde;

  key_evt_t    key_events_due [$];
  term_byte_t  byte_queue [$];
  int unsigned failures;
  int unsigned bytes_taken;
  int unsigned events_checked;
  int unsigned length_closes;
  int unsigned cycle_count;
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Decode the head of a chunk, len being the chunk length capped at five.
  function automatic key_evt_t decode_key(input logic [3:0][7:0] hb, input logic t4,
                                          input int unsigned len);
    key_evt_t   evt;
    logic [4:0] hit;
    evt = '0;
    hit = KC_INCOMPLETE;
    if (hb[0] != ESC_BYTE) begin
      if (hb[0] == CR_BYTE) evt.code = KC_ENTER;
      else if (hb[0] == TAB_BYTE) evt.code = KC_TAB;
      else if (hb[0] == BS_BYTE || hb[0] == DEL_BYTE) evt.code = KC_BACKSPACE;
      else if (hb[0] < CTRL_LIMIT) begin
        evt.code = KC_CHAR;
        evt.ch   = hb[0] + CTRL_BIAS;
        evt.ctrl = 1'b1;
      end else begin
        evt.code = KC_CHAR;
        evt.ch   = hb[0];
      end
      return evt;
    end
    if (len == 1) begin
      evt.code = KC_ESC;
      return evt;
    end
    if (hb[1] == CSI_INTRO) begin
      if (len < 3) return evt;
      case (hb[2])
        "A": hit = KC_UP;
        "B": hit = KC_DOWN;
        "C": hit = KC_RIGHT;
        "D": hit = KC_LEFT;
        "H": hit = KC_HOME;
        "F": hit = KC_END;
        default: hit = KC_INCOMPLETE;
      endcase
      if (hit == KC_INCOMPLETE && hb[2] >= "0" && hb[2] <= "9") begin
        if (len < 4) return evt;
        if (hb[3] == TILDE_BYTE) begin
          case (hb[2])
            "1", "7": hit = KC_HOME;
            "2": hit = KC_INSERT;
            "3": hit = KC_DELETE;
            "4", "8": hit = KC_END;
            "5": hit = KC_PGUP;
            "6": hit = KC_PGDN;
            default: ;
          endcase
        end
        // Two-digit function keys need the closing tilde in the fifth byte.
        if (hit == KC_INCOMPLETE && len >= 5 && t4 && hb[2] == "1") begin
          case (hb[3])
            "5": hit = KC_F5;
            "7": hit = KC_F6;
            "8": hit = KC_F7;
            "9": hit = KC_F8;
            default: ;
          endcase
        end
        if (hit == KC_INCOMPLETE && len >= 5 && t4 && hb[2] == "2") begin
          case (hb[3])
            "0": hit = KC_F9;
            "1": hit = KC_F10;
            "3": hit = KC_F11;
            "4": hit = KC_F12;
            default: ;
          endcase
        end
      end
    end else if (hb[1] == SS3_INTRO) begin
      if (len < 3) return evt;
      case (hb[2])
        "P": hit = KC_F1;
        "Q": hit = KC_F2;
        "R": hit = KC_F3;
        "S": hit = KC_F4;
        default: ;
      endcase
    end
    if (hit != KC_INCOMPLETE) begin
      evt.code = hit;
    end else begin
      // Anything else after ESC reads as Alt plus that byte.
      evt.code = KC_CHAR;
      evt.ch   = hb[1];
      evt.alt  = 1'b1;
    end
    return evt;
  endfunction

  // Advance the chunk tracker by one accepted byte. Returns 1 when the byte
  // closes its chunk, with the key event in evt.
  function automatic bit track_chunk(input logic [7:0] b, input logic last,
                                     output key_evt_t evt);
    logic [3:0][7:0] hb;
    logic            t4;
    int unsigned     len;
    int unsigned     i;
    evt = '0;
    if (!last && chunk_pos + 1 < ChunkBytes) begin
      if (chunk_pos < 4) chunk_head[chunk_pos] = b;
      else if (chunk_pos == 4) fifth_tilde = (b == TILDE_BYTE);
      chunk_pos++;
      return 1'b0;
    end
    if (!last) length_closes++;
    for (i = 0; i < 4; i++) begin
      if (i < chunk_pos) hb[i] = chunk_head[i];
      else if (i == chunk_pos) hb[i] = b;
      else hb[i] = 8'h00;
    end
    t4  = (chunk_pos == 4) ? (b == TILDE_BYTE) : fifth_tilde;
    len = (chunk_pos + 1 > 5) ? 5 : chunk_pos + 1;
    evt = decode_key(hb, t4, len);
    chunk_pos   = 0;
    fifth_tilde = 1'b0;
    return 1'b1;
  endfunction

  // Usually the given byte, now and then a random one.
  function automatic logic [7:0] mostly(input logic [7:0] b);
    return ($urandom_range(0, 5) != 0) ? b : 8'($urandom);
  endfunction

  // Queue one key sequence with random content, sometimes cut short, padded,
  // stretched past the chunk length or left without a burst end.
  task automatic queue_key_sequence();
    logic [7:0]  seq [$];
    int unsigned kind;
    int unsigned shape;
    int unsigned n;
    int unsigned idx;
    bit          close_it;
    term_byte_t  item;
    kind = $urandom_range(0, 9);
    if (kind != 6 && kind != 7) seq.push_back(ESC_BYTE);
    case (kind)
      0, 1: begin
        seq.push_back(CSI_INTRO);
        seq.push_back(mostly(CSI_FINALS[$urandom_range(0, 5)]));
      end
      2: begin
        seq.push_back(CSI_INTRO);
        seq.push_back(8'("0" + $urandom_range(0, 9)));
        seq.push_back(mostly(TILDE_BYTE));
      end
      3, 4: begin
        seq.push_back(CSI_INTRO);
        seq.push_back(mostly($urandom_range(0, 1) ? "2" : "1"));
        seq.push_back(8'("0" + $urandom_range(0, 9)));
        seq.push_back(mostly(TILDE_BYTE));
      end
      5: begin
        seq.push_back(mostly(SS3_INTRO));
        seq.push_back(mostly(SS3_FINALS[$urandom_range(0, 3)]));
      end
      6, 8: seq.push_back(8'($urandom));
      7: seq.push_back(8'($urandom_range(0, 31)));
      default: ;
    endcase
    close_it = 1'b1;
    shape = $urandom_range(0, 19);
    case (shape)
      0, 1: begin
        n = $urandom_range(1, seq.size());
        while (seq.size() > n) void'(seq.pop_back());
      end
      2, 3: repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
      4: begin
        repeat ($urandom_range(12, 20)) seq.push_back(8'($urandom));
        close_it = $urandom_range(0, 1);
      end
      5: close_it = 1'b0;
      default: ;
    endcase
    for (idx = 0; idx < seq.size(); idx++) begin
      item.b    = seq[idx];
      item.last = close_it && (idx == seq.size() - 1);
      byte_queue.push_back(item);
    end
  endtask

  // Offer one byte, with an occasional idle burst ahead of it, and wait for the
  // transaction. Called and returning at a falling edge.
  task automatic offer_byte(input logic [7:0] b, input logic last, input logic typed,
                            input key_evt_t want, input bit gappy);
    key_evt_t evt;
    if (gappy && !calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_taken++;
    if (track_chunk(b, last, evt)) key_events_due.push_back(typed ? want : evt);
    @(negedge clk_i);
  endtask

  initial begin : drive_bytes
    int unsigned idx;
    int unsigned rand_sent;
    bit          gappy;
    term_byte_t  item;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tlast_i  = 1'b0;
    rst_ni          = 1'b0;
    chunk_pos       = 0;
    fifth_tilde     = 1'b0;
    calm            = 1'b0;
    rand_sent       = 0;
    gappy           = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (idx = 0; idx < $size(DIR_TAB); idx++) begin
      offer_byte(DIR_TAB[idx].b, DIR_TAB[idx].last, DIR_TAB[idx].typed,
                 DIR_TAB[idx].want, 1'b0);
    end

    while (rand_sent < RandItems) begin
      if (byte_queue.size() == 0) queue_key_sequence();
      item = byte_queue.pop_front();
      // Sender gaps come in stretches: on for some bytes, off for others.
      if (rand_sent % 64 == 0) gappy = $urandom_range(0, 1);
      calm = (rand_sent >= RandItems - CalmItems);
      offer_byte(item.b, item.last, 1'b0, NO_EVT, gappy);
      rand_sent++;
    end
    s_axis_tvalid_i <= 1'b0;

    while (key_events_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d key events from %0d terminal bytes;", events_checked, bytes_taken);
    $display("%0d chunks were closed by the length limit rather than a burst end.",
             length_closes);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random stall bursts in some stretches, one long hold-off so the
  // output register fills and the slave side stalls, and no stalls at the end.
  initial begin : drain_events
    bit          held;
    bit          stally;
    int unsigned steps;
    held   = 1'b0;
    stally = 1'b0;
    steps  = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && bytes_taken >= HoldAfter) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end else if (stally && !calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        @(negedge clk_i);
      end
      steps++;
      if (steps % 48 == 0) stally = $urandom_range(0, 1);
    end
  end

  // Compare every key event transaction with the oldest prediction.
  always @(posedge clk_i) begin
    key_evt_t got;
    key_evt_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = key_evt_t'(m_axis_tdata_o[14:0]);
      if (key_events_due.size() == 0) begin
        $error("key event with none expected: code %0d char %0h", got.code, got.ch);
        failures++;
      end else begin
        want = key_events_due.pop_front();
        events_checked++;
        if (got.code != want.code) begin
          $error("key_code: expected %0d, got %0d", want.code, got.code);
          failures++;
        end
        if (got.ch != want.ch) begin
          $error("char_value: expected %0h, got %0h", want.ch, got.ch);
          failures++;
        end
        if (got.ctrl != want.ctrl) begin
          $error("ctrl_mod: expected %0b, got %0b", want.ctrl, got.ctrl);
          failures++;
        end
        if (got.alt != want.alt) begin
          $error("alt_mod: expected %0b, got %0b", want.alt, got.alt);
          failures++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d key events outstanding.",
               cycle_count, key_events_due.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule
